[src/bcmp_pkg.sv]
// Package with the modulus, reduction constants and table sizes of the binomial unit.
package bcmp_pkg;
   localparam int TableDepth = 4096;
   localparam int IdxWidth = $clog2(TableDepth);
   localparam int ResWidth = 30;
   localparam int ArgWidth = 21;

   typedef logic [ResWidth-1:0] residue_type;
   typedef logic [IdxWidth-1:0] index_type;

   localparam logic [29:0] ModP = 30'd998244353;
   localparam logic [29:0] ExpInv = 30'd998244351;
   // Barrett factor floor(2^60 / P).
   localparam logic [63:0] MuWide = (64'd1 << 60) / 64'd998244353;
   localparam logic [30:0] Mu = MuWide[30:0];

   localparam logic [2:0] ActBinom = 3'd0;
   localparam logic [2:0] ActArrange = 3'd1;
   localparam logic [2:0] ActFact = 3'd2;
   localparam logic [2:0] ActInvFact = 3'd3;
   localparam logic [2:0] ActInv = 3'd4;
endpackage

[src/bcmp_mulmod.sv]
// Four-stage pipelined multiplier modulo P with Barrett reduction.
module bcmp_mulmod
   import bcmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  residue_type in_a,
   input  residue_type in_b,
   output logic        out_valid,
   output residue_type out_res
);
   logic [3:0]  valid_ff;
   logic [59:0] prod_ff;
   logic [61:0] q2_ff;
   logic [31:0] low_b_ff, low_c_ff;
   logic [31:0] qp_ff;
   residue_type res_ff;
   logic [31:0] diff;
   logic [31:0] two_p;
   logic [61:0] q3p_in;

   assign two_p = {1'b0, ModP, 1'b0};
   assign diff = low_c_ff - qp_ff;
   assign q3p_in = 62'(q2_ff[61:31]) * 62'(ModP);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      prod_ff <= 60'(in_a) * 60'(in_b);
      q2_ff <= 62'(prod_ff[59:29]) * 62'(Mu);
      low_b_ff <= prod_ff[31:0];
      low_c_ff <= low_b_ff;
      qp_ff <= q3p_in[31:0];
      // The estimate is short by at most two times P.
      if (diff >= two_p) begin
         res_ff <= ResWidth'(diff - two_p);
      end else if (diff >= {2'b00, ModP}) begin
         res_ff <= ResWidth'(diff - {2'b00, ModP});
      end else begin
         res_ff <= ResWidth'(diff);
      end
   end

   assign out_valid = valid_ff[3];
   assign out_res = res_ff;
endmodule

[src/binomial_coefficient_mod_prime_unit.sv]
// Top level: table fill sequencer, table memories and query pipeline.
//
//  channel  ports                                  handshake
//  query    req_action, req_arg_n, req_arg_k       start & !busy
//  result   rsp_value, rsp_status                  rsp_valid, one-cycle strobe
//
// One item is accepted per cycle while busy is low; its result passes through the
// table read, two four-stage modular multipliers and an output register.
// After reset the fill sequencer holds busy high while it builds the factorial
// tables through the first multiplier, one product at a time.
// The receiver cannot stall, so results are never held back.
module binomial_coefficient_mod_prime_unit
   import bcmp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_action,
   input  logic [ArgWidth-1:0] req_arg_n,
   input  logic [ArgWidth-1:0] req_arg_k,
   output logic                rsp_valid,
   output logic [ResWidth-1:0] rsp_value,
   output logic                rsp_status
);
   localparam logic [3:0] StInit0  = 4'd0;
   localparam logic [3:0] StFacGo  = 4'd1;
   localparam logic [3:0] StFacW   = 4'd2;
   localparam logic [3:0] StSqGo   = 4'd3;
   localparam logic [3:0] StSqW    = 4'd4;
   localparam logic [3:0] StMlGo   = 4'd5;
   localparam logic [3:0] StMlW    = 4'd6;
   localparam logic [3:0] StPwDone = 4'd7;
   localparam logic [3:0] StDnRd   = 4'd8;
   localparam logic [3:0] StDnM1   = 4'd9;
   localparam logic [3:0] StDnM2   = 4'd10;
   localparam logic [3:0] StDnW1   = 4'd11;
   localparam logic [3:0] StDnW2   = 4'd12;
   localparam logic [3:0] StZero   = 4'd13;
   localparam logic [3:0] StRun    = 4'd14;

   localparam index_type LastIdx = index_type'(TableDepth - 1);
   localparam residue_type One = residue_type'(1);
   localparam residue_type Zero = residue_type'(0);

   // Each word holds the factorial in its upper half and the inverse in its lower half.
   logic [2*ResWidth-1:0] fac_inv_mem [TableDepth];
   residue_type ifac_mem [TableDepth];

   logic [3:0]  state_ff, state_in;
   index_type   idx_ff, idx_in;
   residue_type acc_ff, acc_in;
   residue_type base_ff, base_in;
   logic [4:0]  bit_ff, bit_in;

   // Memory ports.
   index_type   fac_inv_raddr, ifa_raddr, ifb_raddr;
   logic [2*ResWidth-1:0] fac_inv_rd_ff, fac_inv_wdata;
   residue_type fac_rd, inv_rd, ifa_rd_ff, ifb_rd_ff;
   logic        fac_inv_we, ifac_we;
   index_type   fac_inv_waddr, ifac_waddr;
   residue_type ifac_wdata;

   // Multipliers.
   logic        mm1_iv, mm1_ov, mm2_iv, mm2_ov;
   residue_type mm1_a, mm1_b, mm1_res, mm2_a, mm2_b, mm2_res;
   residue_type init_a, init_b;
   logic        init_issue;

   // Query pipeline.
   logic        accept;
   logic        q_zero, q_status;
   logic [ArgWidth-1:0] n_minus_k;
   logic        s1_valid_ff;
   logic [2:0]  s1_act_ff;
   logic        s1_zero_ff, s1_status_ff;
   residue_type s1_a, s1_b1, s1_b2;
   residue_type b2_line_ff [4];
   logic        zero_line_ff [8];
   logic        stat_line_ff [8];
   logic        rsp_valid_ff;
   residue_type rsp_value_ff;
   logic        rsp_status_ff;

   assign busy = (state_ff != StRun);
   assign accept = start && !busy;
   assign n_minus_k = req_arg_n - req_arg_k;

   always_comb begin
      logic n_neg, k_neg, n_lt_k, n_big;
      n_neg = req_arg_n[ArgWidth-1];
      k_neg = req_arg_k[ArgWidth-1];
      n_lt_k = $signed(req_arg_n) < $signed(req_arg_k);
      n_big = $signed({req_arg_n[ArgWidth-1], req_arg_n}) >=
              $signed((ArgWidth+1)'(TableDepth));
      q_zero = 1'b1;
      q_status = 1'b0;
      if (req_action == ActBinom || req_action == ActArrange) begin
         if (k_neg || n_lt_k) begin
            q_status = 1'b0;
         end else if (n_big) begin
            q_status = 1'b1;
         end else begin
            q_zero = 1'b0;
         end
      end else if (req_action == ActFact || req_action == ActInvFact ||
                   req_action == ActInv) begin
         if (n_neg || n_big) begin
            q_status = 1'b1;
         end else begin
            q_zero = 1'b0;
         end
      end
   end

   // Read addresses: the sequencer owns them while busy.
   always_comb begin
      if (busy) begin
         fac_inv_raddr = idx_ff - index_type'(1);
         ifa_raddr = idx_ff;
         ifb_raddr = idx_ff;
      end else begin
         fac_inv_raddr = req_arg_n[IdxWidth-1:0];
         ifa_raddr = (req_action == ActInvFact) ? req_arg_n[IdxWidth-1:0]
                                                : n_minus_k[IdxWidth-1:0];
         ifb_raddr = req_arg_k[IdxWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (fac_inv_we) begin
         fac_inv_mem[fac_inv_waddr] <= fac_inv_wdata;
      end
      fac_inv_rd_ff <= fac_inv_mem[fac_inv_raddr];
   end

   assign fac_rd = fac_inv_rd_ff[2*ResWidth-1:ResWidth];
   assign inv_rd = fac_inv_rd_ff[ResWidth-1:0];

   always_ff @(posedge clock) begin
      if (ifac_we) begin
         ifac_mem[ifac_waddr] <= ifac_wdata;
      end
      ifa_rd_ff <= ifac_mem[ifa_raddr];
      ifb_rd_ff <= ifac_mem[ifb_raddr];
   end

   // Fill sequencer: factorials upward, Fermat inverse, then inverse factorials and inverses downward.
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      acc_in = acc_ff;
      base_in = base_ff;
      bit_in = bit_ff;
      init_issue = 1'b0;
      init_a = acc_ff;
      init_b = acc_ff;
      fac_inv_we = 1'b0;
      fac_inv_waddr = idx_ff;
      fac_inv_wdata = {mm1_res, Zero};
      ifac_we = 1'b0;
      ifac_waddr = idx_ff - index_type'(1);
      ifac_wdata = mm1_res;
      unique case (state_ff)
         StInit0: begin
            fac_inv_we = 1'b1;
            fac_inv_waddr = '0;
            fac_inv_wdata = {One, Zero};
            acc_in = One;
            idx_in = index_type'(1);
            state_in = StFacGo;
         end
         StFacGo: begin
            init_issue = 1'b1;
            init_b = residue_type'(idx_ff);
            state_in = StFacW;
         end
         StFacW: begin
            if (mm1_ov) begin
               fac_inv_we = 1'b1;
               acc_in = mm1_res;
               if (idx_ff == LastIdx) begin
                  base_in = mm1_res;
                  acc_in = One;
                  bit_in = 5'(ResWidth - 1);
                  state_in = StSqGo;
               end else begin
                  idx_in = idx_ff + index_type'(1);
                  state_in = StFacGo;
               end
            end
         end
         StSqGo: begin
            init_issue = 1'b1;
            state_in = StSqW;
         end
         StSqW: begin
            if (mm1_ov) begin
               acc_in = mm1_res;
               if (ExpInv[bit_ff]) begin
                  state_in = StMlGo;
               end else if (bit_ff == '0) begin
                  state_in = StPwDone;
               end else begin
                  bit_in = bit_ff - 5'd1;
                  state_in = StSqGo;
               end
            end
         end
         StMlGo: begin
            init_issue = 1'b1;
            init_b = base_ff;
            state_in = StMlW;
         end
         StMlW: begin
            if (mm1_ov) begin
               acc_in = mm1_res;
               if (bit_ff == '0) begin
                  state_in = StPwDone;
               end else begin
                  bit_in = bit_ff - 5'd1;
                  state_in = StSqGo;
               end
            end
         end
         StPwDone: begin
            ifac_we = 1'b1;
            ifac_waddr = LastIdx;
            ifac_wdata = acc_ff;
            idx_in = LastIdx;
            state_in = StDnRd;
         end
         StDnRd: begin
            state_in = StDnM1;
         end
         StDnM1: begin
            init_issue = 1'b1;
            init_b = residue_type'(idx_ff);
            state_in = StDnM2;
         end
         StDnM2: begin
            // The factorial read of the previous index is still on the port.
            init_issue = 1'b1;
            init_b = fac_rd;
            state_in = StDnW1;
         end
         StDnW1: begin
            if (mm1_ov) begin
               ifac_we = 1'b1;
               acc_in = mm1_res;
               state_in = StDnW2;
            end
         end
         StDnW2: begin
            if (mm1_ov) begin
               // During the downward walk base_ff holds the factorial of the
               // current index, so the whole word can be rewritten.
               fac_inv_we = 1'b1;
               fac_inv_wdata = {base_ff, mm1_res};
               if (idx_ff == index_type'(1)) begin
                  state_in = StZero;
               end else begin
                  base_in = fac_rd;
                  idx_in = idx_ff - index_type'(1);
                  state_in = StDnRd;
               end
            end
         end
         StZero: begin
            fac_inv_we = 1'b1;
            fac_inv_waddr = '0;
            fac_inv_wdata = {One, Zero};
            state_in = StRun;
         end
         StRun: begin
            state_in = StRun;
         end
         default: begin
            state_in = StInit0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StInit0;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      base_ff <= base_in;
      bit_ff <= bit_in;
   end

   // Query stage after the table read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_act_ff <= req_action;
      s1_zero_ff <= q_zero;
      s1_status_ff <= q_status;
   end

   always_comb begin
      unique case (s1_act_ff)
         ActInvFact: s1_a = ifa_rd_ff;
         ActInv:     s1_a = inv_rd;
         default:    s1_a = fac_rd;
      endcase
      s1_b1 = (s1_act_ff == ActBinom || s1_act_ff == ActArrange) ? ifa_rd_ff : One;
      s1_b2 = (s1_act_ff == ActBinom) ? ifb_rd_ff : One;
   end

   assign mm1_iv = busy ? init_issue : s1_valid_ff;
   assign mm1_a = busy ? init_a : s1_a;
   assign mm1_b = busy ? init_b : s1_b1;

   bcmp_mulmod u_mm1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mm1_iv),
      .in_a      (mm1_a),
      .in_b      (mm1_b),
      .out_valid (mm1_ov),
      .out_res   (mm1_res)
   );

   always_ff @(posedge clock) begin
      b2_line_ff[0] <= s1_b2;
      for (int i = 1; i < 4; i++) begin
         b2_line_ff[i] <= b2_line_ff[i-1];
      end
      zero_line_ff[0] <= s1_zero_ff;
      stat_line_ff[0] <= s1_status_ff;
      for (int i = 1; i < 8; i++) begin
         zero_line_ff[i] <= zero_line_ff[i-1];
         stat_line_ff[i] <= stat_line_ff[i-1];
      end
   end

   // Fill products never reach the second multiplier.
   assign mm2_iv = mm1_ov && !busy;
   assign mm2_a = mm1_res;
   assign mm2_b = b2_line_ff[3];

   bcmp_mulmod u_mm2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mm2_iv),
      .in_a      (mm2_a),
      .in_b      (mm2_b),
      .out_valid (mm2_ov),
      .out_res   (mm2_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= mm2_ov;
      end
      rsp_value_ff <= zero_line_ff[7] ? '0 : mm2_res;
      rsp_status_ff <= stat_line_ff[7];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
endmodule
